/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/lia_pkg.sv */
// ----------------------------------------------------------------------------
// lia_pkg
// fixed formats and arctangent table for the line inclination angle unit
// ----------------------------------------------------------------------------
`default_nettype none

package lia_pkg;

  // width of every coordinate and angle port
  localparam int unsigned FIELD_W = 16;

  // angle accumulator: degrees with 20 fraction bits
  localparam int unsigned Z_FRAC = 20;
  localparam int unsigned Z_W    = 32;

  // x/y datapath: deltas scaled to bit 56, with room for cordic gain
  localparam int unsigned XY_TOP = 56;
  localparam int unsigned XY_W   = 60;

  localparam logic signed [Z_W-1:0] Z_DEG180 = Z_W'(180 * (2 ** Z_FRAC));
  localparam logic signed [Z_W-1:0] Z_DEG360 = Z_W'(360 * (2 ** Z_FRAC));

  // atan(2^-i) in degrees, 20 fraction bits
  localparam logic signed [Z_W-1:0] ATAN_TAB [32] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7,
    32'sd4,        32'sd2,        32'sd1,        32'sd0,
    32'sd0,        32'sd0,        32'sd0,        32'sd0
  };

endpackage

`default_nettype wire

/* rtl/line_inclination_angle_unit.sv */
// ----------------------------------------------------------------------------
// line_inclination_angle_unit
// stages in order: input stage d, stage c0, the cordic rotation stages, output stage
// throughput: one segment per cycle while out_stall_i allows, one cordic iteration per stage
// a stage frees up when its beat moves on, so bubbles close under back-pressure
// reset clears all valid bits at once; the pipe is empty and accepts at once
// ----------------------------------------------------------------------------
`default_nettype none

module line_inclination_angle_unit #(
  parameter int unsigned COORD_WIDTH         = 16,
  parameter int unsigned CORDIC_STAGES       = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 7
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [lia_pkg::FIELD_W-1:0]     start_x_i,
  input  wire  [lia_pkg::FIELD_W-1:0]     start_y_i,
  input  wire  [lia_pkg::FIELD_W-1:0]     end_x_i,
  input  wire  [lia_pkg::FIELD_W-1:0]     end_y_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [lia_pkg::FIELD_W-1:0]     angle_o
);

  import lia_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned NS    = CORDIC_STAGES;
  localparam int unsigned AFB   = ANGLE_FRACTION_BITS;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned SCL   = XY_TOP - CW;
  localparam int unsigned RES_W = 9 + AFB;
  localparam int unsigned SH    = Z_FRAC - AFB;
  localparam logic [RES_W-1:0] DEG0   = '0;
  localparam logic [RES_W-1:0] DEG90  = RES_W'(90 * (2 ** AFB));
  localparam logic [RES_W-1:0] DEG180 = RES_W'(180 * (2 ** AFB));
  localparam logic [RES_W-1:0] DEG270 = RES_W'(270 * (2 ** AFB));
  localparam logic [RES_W-1:0] FULL   = RES_W'(360 * (2 ** AFB));
  localparam logic [Z_W:0]     RND    = (Z_W+1)'(2 ** (SH - 1));

  // ---------------------------------------------------------------------------
  // flow control: a stage takes a beat when empty or when its own beat leaves
  // ---------------------------------------------------------------------------
  logic out_vld_q;
  logic out_free;
  logic d_vld_q;
  logic d_free;

  wire                    c_vld  [NS+1];
  wire                    c_free [NS+1];
  wire signed [XY_W-1:0]  cx     [NS+1];
  wire signed [XY_W-1:0]  cy     [NS+1];
  wire signed [Z_W-1:0]   cz     [NS+1];
  wire                    csp    [NS+1];
  wire        [RES_W-1:0] cspv   [NS+1];

  assign out_free     = !out_vld_q || !out_stall_i;
  assign c_free[NS]   = !c_vld[NS] || out_free;
  assign c_free[0]    = !c_vld[0] || c_free[1];
  assign d_free       = !d_vld_q || c_free[0];
  assign in_stall_o   = !d_free;

  // ---------------------------------------------------------------------------
  // stage d: take the low coordinate bits and form the deltas
  // ---------------------------------------------------------------------------
  logic [FIELD_W+CW-1:0] sx_ext, sy_ext, ex_ext, ey_ext;
  logic [CW-1:0]         sx_c, sy_c, ex_c, ey_c;
  logic signed [DW-1:0]  dx_d, dy_d;
  logic signed [DW-1:0]  dx_q, dy_q;

  always_comb begin
    sx_ext = {{CW{1'b0}}, start_x_i};
    sy_ext = {{CW{1'b0}}, start_y_i};
    ex_ext = {{CW{1'b0}}, end_x_i};
    ey_ext = {{CW{1'b0}}, end_y_i};
    sx_c   = sx_ext[CW-1:0];
    sy_c   = sy_ext[CW-1:0];
    ex_c   = ex_ext[CW-1:0];
    ey_c   = ey_ext[CW-1:0];
    dx_d   = $signed({ex_c[CW-1], ex_c}) - $signed({sx_c[CW-1], sx_c});
    dy_d   = $signed({ey_c[CW-1], ey_c}) - $signed({sy_c[CW-1], sy_c});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (d_free) begin
      d_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_free) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c0: special cases, fold into right half plane, scale up
  // ---------------------------------------------------------------------------
  logic                   c0_vld_q;
  logic signed [XY_W-1:0] x0_d, y0_d, x0_q, y0_q;
  logic signed [Z_W-1:0]  z0_d, z0_q;
  logic                   sp0_d, sp0_q;
  logic [RES_W-1:0]       spv0_d, spv0_q;
  logic signed [DW:0]     dxn, dyn;

  always_comb begin
    dxn    = {dx_q[DW-1], dx_q};
    dyn    = {dy_q[DW-1], dy_q};
    z0_d   = '0;
    if (dx_q[DW-1]) begin
      dxn  = -dxn;
      dyn  = -dyn;
      z0_d = Z_DEG180;
    end
    x0_d   = XY_W'($signed({dxn, {SCL{1'b0}}}));
    y0_d   = XY_W'($signed({dyn, {SCL{1'b0}}}));
    sp0_d  = 1'b0;
    spv0_d = DEG0;
    if (dx_q == '0) begin
      // vertical line, zero length lands on the downward direction
      sp0_d  = 1'b1;
      spv0_d = (!dy_q[DW-1] && (dy_q != '0)) ? DEG90 : DEG270;
    end else if (dy_q == '0) begin
      // horizontal line
      sp0_d  = 1'b1;
      spv0_d = dx_q[DW-1] ? DEG180 : DEG0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_vld_q <= 1'b0;
    end else if (c_free[0]) begin
      c0_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_free[0]) begin
      x0_q   <= x0_d;
      y0_q   <= y0_d;
      z0_q   <= z0_d;
      sp0_q  <= sp0_d;
      spv0_q <= spv0_d;
    end
  end

  assign c_vld[0] = c0_vld_q;
  assign cx[0]    = x0_q;
  assign cy[0]    = y0_q;
  assign cz[0]    = z0_q;
  assign csp[0]   = sp0_q;
  assign cspv[0]  = spv0_q;

  // ---------------------------------------------------------------------------
  // cordic vectoring stages, one rotation each
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic                   vld_q;
    logic signed [XY_W-1:0] x_d, y_d, x_q, y_q;
    logic signed [Z_W-1:0]  z_d, z_q;
    logic                   sp_q;
    logic [RES_W-1:0]       spv_q;
    logic signed [XY_W-1:0] xs, ys;

    if (i < NS - 1) begin : g_free
      assign c_free[i+1] = !c_vld[i+1] || c_free[i+2];
    end

    // rotate toward the x axis, direction from the sign of y
    always_comb begin
      xs = cx[i] >>> i;
      ys = cy[i] >>> i;
      if (!cy[i][XY_W-1]) begin
        x_d = cx[i] + ys;
        y_d = cy[i] - xs;
        z_d = cz[i] + ATAN_TAB[i % 32];
      end else begin
        x_d = cx[i] - ys;
        y_d = cy[i] + xs;
        z_d = cz[i] - ATAN_TAB[i % 32];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (c_free[i+1]) begin
        vld_q <= c_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (c_free[i+1]) begin
        x_q   <= x_d;
        y_q   <= y_d;
        z_q   <= z_d;
        sp_q  <= csp[i];
        spv_q <= cspv[i];
      end
    end

    assign c_vld[i+1] = vld_q;
    assign cx[i+1]    = x_q;
    assign cy[i+1]    = y_q;
    assign cz[i+1]    = z_q;
    assign csp[i+1]   = sp_q;
    assign cspv[i+1]  = spv_q;
  end

  // ---------------------------------------------------------------------------
  // output stage: bring angle into [0, 360), round to output units, wrap
  // ---------------------------------------------------------------------------
  logic signed [Z_W-1:0]   theta;
  logic [Z_W:0]            rsum;
  logic [Z_W:0]            rsh;
  logic [RES_W-1:0]        res_d, res_q;
  logic [FIELD_W+RES_W-1:0] res_ext;

  always_comb begin
    theta = cz[NS];
    if (theta[Z_W-1]) begin
      theta = theta + Z_DEG360;
    end
    if (theta[Z_W-1]) begin
      theta = '0;
    end
    rsum = {1'b0, theta} + RND;
    rsh  = rsum >> SH;
    if (rsh >= (Z_W+1)'(FULL)) begin
      rsh = rsh - (Z_W+1)'(FULL);
    end
    res_d = csp[NS] ? cspv[NS] : rsh[RES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= c_vld[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      res_q <= res_d;
    end
  end

  assign res_ext     = {{FIELD_W{1'b0}}, res_q};
  assign out_valid_o = out_vld_q;
  assign angle_o     = res_ext[FIELD_W-1:0];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPL(a_angle_range, out_vld_q, res_q < FULL, "angle beyond full turn")
  `ASSERT_IMPL(a_stall_full, in_stall_o, d_vld_q, "input stalled with first stage empty")
  `ASSERT_NEXT(a_last_moves, c_vld[NS] && out_free, out_vld_q, "last stage beat lost")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line inclination angle unit: a table of
// directed segments, then random segments in bursts, each checked against a
// fixed or cordic-predicted angle, with random back-pressure and one long hold-off
// ----------------------------------------------------------------------------

module tb_top;

  // angle codes in 1/128 degree units
  localparam int unsigned FRAC_BITS  = 7;
  localparam logic [15:0] ANG_0      = 16'd0;
  localparam logic [15:0] ANG_90     = 16'(90 << FRAC_BITS);
  localparam logic [15:0] ANG_180    = 16'(180 << FRAC_BITS);
  localparam logic [15:0] ANG_270    = 16'(270 << FRAC_BITS);
  localparam longint      ANG_FULL   = longint'(360) << FRAC_BITS;

  // predictor formats
  localparam int unsigned ACC_FRAC   = 20;
  localparam int unsigned SCALE_SH   = 40;
  localparam int unsigned STAGES     = 16;
  localparam longint      ACC_180    = longint'(180) << ACC_FRAC;
  localparam longint      ACC_360    = longint'(360) << ACC_FRAC;
  localparam int unsigned ROUND_SH   = ACC_FRAC - FRAC_BITS;

  // coordinate extremes
  localparam logic [15:0] C_MIN      = 16'h8000;
  localparam logic [15:0] C_MAX      = 16'h7FFF;
  localparam logic [15:0] C_NEG1     = 16'hFFFF;

  // run shape
  localparam int N_RANDOM    = 720;
  localparam int N_PRESSURE  = 60;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYC   = 50;
  localparam int QUIET_LIMIT = 3000;
  localparam int N_ROWS      = 22;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic        known;
    logic [15:0] angle;
  } seg_row_t;

  typedef enum int {HOLD_IDLE, HOLD_REQ, HOLD_ON} hold_state_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [15:0] start_x_i   = '0;
  logic [15:0] start_y_i   = '0;
  logic [15:0] end_x_i     = '0;
  logic [15:0] end_y_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] angle_o;

  logic [15:0] angle_q [$];
  logic [15:0] want_angle;
  int          fail_cnt    = 0;
  int          quiet_cycles = 0;
  hold_state_e hold_state  = HOLD_IDLE;
  seg_row_t    dir_rows [N_ROWS];

  line_inclination_angle_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_o     (angle_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // cordic vectoring angle of the segment, rounded to 1/128 degree
  function automatic logic [15:0] cordic_angle(input logic [15:0] sx, input logic [15:0] sy,
                                               input logic [15:0] ex, input logic [15:0] ey);
    longint dx, dy, xa, ya, za, xs, ys, step, rnd;
    dx = longint'($signed(ex)) - longint'($signed(sx));
    dy = longint'($signed(ey)) - longint'($signed(sy));
    if (dx == 0) return (dy > 0) ? ANG_90 : ANG_270;
    if (dy == 0) return (dx > 0) ? ANG_0 : ANG_180;
    za = 0;
    // fold into the right half plane
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      za = ACC_180;
    end
    xa = dx <<< SCALE_SH;
    ya = dy <<< SCALE_SH;
    for (int i = 0; i < STAGES; i++) begin
      case (i)
        0:       step = 47185920;
        1:       step = 27855475;
        2:       step = 14718068;
        3:       step = 7471121;
        4:       step = 3750058;
        5:       step = 1876857;
        6:       step = 938658;
        7:       step = 469357;
        8:       step = 234682;
        9:       step = 117342;
        10:      step = 58671;
        11:      step = 29335;
        12:      step = 14668;
        13:      step = 7334;
        14:      step = 3667;
        default: step = 1833;
      endcase
      xs = xa >>> i;
      ys = ya >>> i;
      if (ya >= 0) begin
        xa = xa + ys;
        ya = ya - xs;
        za = za + step;
      end else begin
        xa = xa - ys;
        ya = ya + xs;
        za = za - step;
      end
    end
    if (za < 0) za = za + ACC_360;
    if (za < 0) za = 0;
    rnd = (za + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
    while (rnd >= ANG_FULL) rnd = rnd - ANG_FULL;
    return rnd[15:0];
  endfunction

  // one of the interesting coordinate values
  function automatic logic [15:0] corner_coord();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 16'd0;
      3:       return C_NEG1;
      default: return 16'd1;
    endcase
  endfunction

  // offer one segment beat and hold it until accepted
  task automatic send_seg(input logic [15:0] sx, input logic [15:0] sy,
                          input logic [15:0] ex, input logic [15:0] ey,
                          input logic known, input logic [15:0] known_angle);
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    angle_q.push_back(known ? known_angle : cordic_angle(sx, sy, ex, ey));
  endtask

  // random segment, weighted toward the special lines
  task automatic send_random_seg();
    logic [15:0] sx, sy, ex, ey;
    sx = 16'($urandom);
    sy = 16'($urandom);
    ex = 16'($urandom);
    ey = 16'($urandom);
    case ($urandom_range(0, 11))
      0:  ex = sx;
      1:  ey = sy;
      2:  begin
        ex = sx;
        ey = sy;
      end
      3:  begin
        ex = sx + 16'($urandom_range(0, 8)) - 16'd4;
        ey = sy + 16'($urandom_range(0, 8)) - 16'd4;
      end
      4:  begin
        sx = corner_coord();
        sy = corner_coord();
        ex = corner_coord();
        ey = corner_coord();
      end
      default: ;
    endcase
    send_seg(sx, sy, ex, ey, 1'b0, ANG_0);
  endtask

  // idle gap on the input side
  task automatic input_gap(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // stimulus
  initial begin
    int burst;
    dir_rows = '{
      // zero-length segments
      '{16'd0,  16'd0,  16'd0,  16'd0,  1'b1, ANG_270},
      '{C_MIN,  C_MAX,  C_MIN,  C_MAX,  1'b1, ANG_270},
      // vertical lines
      '{16'd5,  C_NEG1 - 16'd2, 16'd5, 16'd4, 1'b1, ANG_90},
      '{16'd0,  C_MIN,  16'd0,  C_MAX,  1'b1, ANG_90},
      '{16'd0,  C_MAX,  16'd0,  C_MIN,  1'b1, ANG_270},
      // horizontal lines
      '{C_MIN,  16'd0,  C_MAX,  16'd0,  1'b1, ANG_0},
      '{C_MAX,  16'd7,  C_MIN,  16'd7,  1'b1, ANG_180},
      '{16'd0,  16'd0,  16'd1,  16'd0,  1'b1, ANG_0},
      '{16'd0,  16'd0,  C_NEG1, 16'd0,  1'b1, ANG_180},
      // diagonals in each quadrant
      '{16'd0,  16'd0,  16'd1,  16'd1,  1'b0, ANG_0},
      '{16'd0,  16'd0,  C_NEG1, 16'd1,  1'b0, ANG_0},
      '{16'd0,  16'd0,  C_NEG1, C_NEG1, 1'b0, ANG_0},
      '{16'd0,  16'd0,  16'd1,  C_NEG1, 1'b0, ANG_0},
      '{C_NEG1, C_NEG1, 16'd0,  16'd0,  1'b0, ANG_0},
      // full-range corners
      '{C_MIN,  C_MIN,  C_MAX,  C_MAX,  1'b0, ANG_0},
      '{C_MAX,  C_MAX,  C_MIN,  C_MIN,  1'b0, ANG_0},
      '{C_MIN,  C_MAX,  C_MAX,  C_MIN,  1'b0, ANG_0},
      '{C_MAX,  C_MIN,  C_MIN,  C_MAX,  1'b0, ANG_0},
      // just under a full turn, just under a half turn
      '{C_MIN,  16'd0,  C_MAX,  C_NEG1, 1'b0, ANG_0},
      '{C_MAX,  16'd0,  C_MIN,  16'd1,  1'b0, ANG_0},
      // near-vertical
      '{16'd0,  C_MIN,  16'd1,  C_MAX,  1'b0, ANG_0},
      '{16'd0,  C_MAX,  C_NEG1, C_MIN,  1'b0, ANG_0}
    };

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      input_gap(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      send_seg(dir_rows[r].sx, dir_rows[r].sy, dir_rows[r].ex, dir_rows[r].ey,
               dir_rows[r].known, dir_rows[r].angle);
    end

    // long receiver hold-off with the input kept busy
    in_valid_i <= 1'b0;
    hold_state = HOLD_REQ;
    while (hold_state != HOLD_ON) @(posedge clk_i);
    for (int n = 0; n < N_PRESSURE; n++) send_random_seg();

    // random bursts
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        input_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      end
      send_random_seg();
      burst--;
    end
    in_valid_i <= 1'b0;

    // drain
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int len;
    int mode;
    logic stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_state == HOLD_REQ) begin
        hold_state = HOLD_ON;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_state = HOLD_IDLE;
      end else begin
        len  = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        for (int c = 0; c < len; c++) begin
          case (mode)
            0:       stall = 1'b0;
            1:       stall = ($urandom_range(0, 3) == 0);
            2:       stall = ($urandom_range(0, 3) != 0);
            default: stall = (c % 3 == 0);
          endcase
          out_stall_i <= stall;
          @(posedge clk_i);
        end
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (angle_q.size() == 0) begin
        $error("angle beat with nothing expected: actual %0d", angle_o);
        fail_cnt++;
      end else begin
        want_angle = angle_q.pop_front();
        if (angle_o !== want_angle) begin
          $error("angle mismatch: expected %0d, actual %0d", want_angle, angle_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
